[design/sabs_pkg.sv]
// Shared types and constants for the sorted array binary search unit.
// Holds operation, status and register codes, the controller state type and
// the command and status bundles between the controller and the datapath.
package sabs_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 7;
  localparam int CAP_W = 7;
  localparam int MODE_W = 2;
  localparam int OP_W = 3;
  localparam int STATUS_W = 3;
  localparam int POS_W = 6;
  localparam int SLOT_W = 6;
  localparam int PRED_W = 7;
  localparam int IO_KEY_W = 32;
  localparam int ECOUNT_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 4'd0,
    REG_MODE     = 4'd1
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_FIND       = 3'd0,
    OP_INSERT     = 3'd1,
    OP_REMOVE_KEY = 3'd2,
    OP_REMOVE_IDX = 3'd3,
    OP_GET        = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRCH_END,
    S_FETCH,
    S_MV_RD,
    S_MV_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic srch_step;
    logic rd_pos;
    logic fetch;
    logic mv_init;
    logic rd_src;
    logic wr_move;
    logic mv_finish;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic oob;
    logic found;
    logic srch_more;
    logic cmp_eq;
    logic move_more;
    logic out_free;
  } dp_stat_t;

endpackage

[design/sabs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the entry store of the sorted array unit.
module sabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sabs_ctrl.sv]
// Controller state machine of the sorted array unit.
// Depends on sabs_pkg for the state type and the command and status bundles.
module sabs_ctrl
  import sabs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op) inside
          OP_FIND, OP_REMOVE_KEY: begin
            state_nxt = S_SRCH_RD;
          end
          OP_INSERT: begin
            state_nxt = stat.full ? S_RESULT : S_SRCH_RD;
          end
          OP_REMOVE_IDX, OP_GET: begin
            if (stat.oob) begin
              state_nxt = S_RESULT;
            end else begin
              cmd.rd_pos = 1'b1;
              state_nxt = S_FETCH;
            end
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (stat.srch_more) begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_SRCH_CMP;
        end else begin
          state_nxt = S_SRCH_END;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt = stat.cmp_eq ? S_SRCH_END : S_SRCH_RD;
      end
      S_SRCH_END: begin
        if ((stat.op == OP_INSERT && !stat.found) ||
            (stat.op == OP_REMOVE_KEY && stat.found)) begin
          cmd.mv_init = 1'b1;
          state_nxt = S_MV_RD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.op == OP_REMOVE_IDX) begin
          cmd.mv_init = 1'b1;
          state_nxt = S_MV_RD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_MV_RD: begin
        if (stat.move_more) begin
          cmd.rd_src = 1'b1;
          state_nxt = S_MV_WR;
        end else begin
          cmd.mv_finish = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_MV_WR: begin
        cmd.wr_move = 1'b1;
        state_nxt = S_MV_RD;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[design/sabs_dp.sv]
// Datapath of the sorted array unit: configuration, search window, shift
// pointer, entry memory and output register. Depends on sabs_pkg and sabs_ram.
module sabs_dp
  import sabs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [IO_KEY_W-1:0]   in_key,
  input  logic [POS_W-1:0]      in_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_W-1:0]     out_slot,
  output logic signed [PRED_W-1:0] out_predecessor,
  output logic [IO_KEY_W-1:0]   out_key_out,
  output logic [ECOUNT_W-1:0]   out_entry_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PXW = (CW > POS_W) ? CW : POS_W;
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]     cap_r;
  logic [MODE_W-1:0]    mode_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        lo_r;
  logic [CW-1:0]        hi1_r;
  logic [CW-1:0]        pre1_r;
  logic [AW-1:0]        mid_r;
  logic [AW-1:0]        d_r;
  op_t                  op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [POS_W-1:0]     pos_r;
  logic                 full_r;
  logic                 oob_r;
  logic                 found_r;
  logic [KEY_WIDTH-1:0] key_out_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [PRED_W-1:0]    out_pred_r;
  logic [IO_KEY_W-1:0]  out_key_r;
  logic [ECOUNT_W-1:0]  out_count_r;

  logic [CW:0]          mid_sum;
  logic [AW-1:0]        mid_c;
  logic [AW-1:0]        src_idx;
  logic                 is_insert;
  logic [LW-1:0]        limit;
  logic                 full_c;
  logic                 oob_c;
  logic [KEY_WIDTH-1:0] rdata;
  logic [KEY_WIDTH-1:0] a_ord;
  logic [KEY_WIDTH-1:0] b_ord;
  logic                 cmp_eq;
  logic                 cmp_lt;
  logic                 cmp_less;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [PRED_W-1:0]    res_pred;
  logic [IO_KEY_W-1:0]  res_key;

  assign cfg_ready = 1'b1;
  assign is_insert = (op_r == OP_INSERT);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (CW + 1)'(1);
  assign mid_c = mid_sum[AW:1];
  assign src_idx = is_insert ? (d_r - AW'(1)) : (d_r + AW'(1));

  assign limit = (LW'(cap_r) < LW'(DEPTH)) ? LW'(cap_r) : LW'(DEPTH);
  assign full_c = LW'(count_r) >= limit;
  assign oob_c = PXW'(in_position) >= PXW'(count_r);

  // Ordering: sign flip for signed keys, then swap the sense for descending.
  assign a_ord = rdata ^ {mode_r[0], {(KEY_WIDTH - 1){1'b0}}};
  assign b_ord = key_r ^ {mode_r[0], {(KEY_WIDTH - 1){1'b0}}};
  assign cmp_eq = (a_ord == b_ord);
  assign cmp_lt = (a_ord < b_ord);
  assign cmp_less = mode_r[1] ? (!cmp_lt && !cmp_eq) : cmp_lt;

  assign stat.op = op_r;
  assign stat.full = full_r;
  assign stat.oob = oob_r;
  assign stat.found = found_r;
  assign stat.srch_more = (lo_r < hi1_r);
  assign stat.cmp_eq = cmp_eq;
  assign stat.move_more = is_insert ? (CW'(d_r) > pre1_r)
                                    : ((CW'(d_r) + CW'(1)) < count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    rd_en = cmd.rd_mid | cmd.rd_pos | cmd.rd_src;
    rd_addr = src_idx;
    if (cmd.rd_mid) begin
      rd_addr = mid_c;
    end else if (cmd.rd_pos) begin
      rd_addr = AW'(pos_r);
    end
    wr_en = cmd.wr_move | (cmd.mv_finish & is_insert);
    wr_addr = d_r;
    wr_data = rdata;
    if (cmd.mv_finish) begin
      wr_addr = AW'(pre1_r);
      wr_data = key_r;
    end
  end

  sabs_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      mode_r <= '0;
      count_r <= '0;
      lo_r <= '0;
      hi1_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_CAPACITY: cap_r <= cfg_data[CAP_W-1:0];
          REG_MODE:     mode_r <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        lo_r <= '0;
        hi1_r <= count_r;
      end else if (cmd.srch_step && !cmp_eq) begin
        if (cmp_less) begin
          lo_r <= CW'(mid_r) + CW'(1);
        end else begin
          hi1_r <= CW'(mid_r);
        end
      end
      if (cmd.mv_finish) begin
        count_r <= is_insert ? (count_r + CW'(1)) : (count_r - CW'(1));
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_operation);
      key_r <= KEY_WIDTH'(in_key);
      pos_r <= in_position;
      full_r <= full_c;
      oob_r <= oob_c;
      found_r <= 1'b0;
      pre1_r <= '0;
    end else if (cmd.srch_step) begin
      if (cmp_eq) begin
        found_r <= 1'b1;
        pre1_r <= CW'(mid_r);
      end else if (cmp_less) begin
        pre1_r <= CW'(mid_r) + CW'(1);
      end
    end
    if (cmd.rd_mid) begin
      mid_r <= mid_c;
    end
    if ((cmd.srch_step && cmp_eq) || cmd.fetch) begin
      key_out_r <= rdata;
    end
    if (cmd.mv_init) begin
      if (is_insert) begin
        d_r <= AW'(count_r);
      end else if (op_r == OP_REMOVE_KEY) begin
        d_r <= mid_r;
      end else begin
        d_r <= AW'(pos_r);
      end
    end else if (cmd.wr_move) begin
      d_r <= src_idx;
    end
    if (cmd.emit) begin
      out_status_r <= res_status;
      out_slot_r <= res_slot;
      out_pred_r <= res_pred;
      out_key_r <= res_key;
      out_count_r <= ECOUNT_W'(count_r);
    end
  end

  always_comb begin
    res_status = ST_DONE;
    res_slot = '0;
    res_pred = '0;
    res_key = '0;
    case (op_r) inside
      OP_FIND: begin
        res_pred = PRED_W'(pre1_r) - PRED_W'(1);
        if (found_r) begin
          res_slot = SLOT_W'(mid_r);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        if (full_r) begin
          res_status = ST_FULL;
        end else if (found_r) begin
          res_status = ST_PRESENT;
          res_slot = SLOT_W'(mid_r);
        end else begin
          res_slot = SLOT_W'(pre1_r);
        end
      end
      OP_REMOVE_KEY: begin
        if (found_r) begin
          res_slot = SLOT_W'(mid_r);
          res_key = IO_KEY_W'(key_out_r);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE_IDX, OP_GET: begin
        if (oob_r) begin
          res_status = ST_RANGE;
        end else begin
          res_slot = SLOT_W'(pos_r);
          res_key = IO_KEY_W'(key_out_r);
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot = out_slot_r;
  assign out_predecessor = out_pred_r;
  assign out_key_out = out_key_r;
  assign out_entry_count = out_count_r;

  // The table never holds more entries than the memory is deep.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds memory depth");

  // The search window never inverts.
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi1_r)
    else $error("search window inverted");

  // An insert that finishes its shift adds exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mv_finish && op_r == OP_INSERT) |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not add one entry");

  // A removal that finishes its shift drops exactly one entry.
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mv_finish && op_r != OP_INSERT) |=> count_r == $past(count_r) - CW'(1))
    else $error("removal did not drop one entry");

endmodule

[design/sorted_array_binary_search_unit.sv]
// Top level of the sorted array unit: joins the controller and the datapath.
// Depends on sabs_pkg, sabs_ctrl and sabs_dp.
//
// The unit keeps up to min(capacity_limit, DEPTH) distinct keys sorted in a
// single-port-read memory and serves one operation at a time. Every access to
// a stored key goes through the one registered read port, which sets the cost.
// A find makes at most ceil(log2(count + 1)) binary search probes, each a
// read of the memory and then a compare. An insert or a removal shifts the
// entries behind its slot one at a time, each a read and then a write. A get
// reads one entry; an out-of-range request, a refused insert or an unused
// operation code reads none.
// Configuration writes are accepted every cycle and are meant to be issued
// only while the unit is idle. The entry memory needs no clearing after reset;
// only entries below the count are ever read.
module sorted_array_binary_search_unit
  import sabs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [IO_KEY_W-1:0]      in_key,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic signed [PRED_W-1:0] out_predecessor,
  output logic [IO_KEY_W-1:0]      out_key_out,
  output logic [ECOUNT_W-1:0]      out_entry_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sabs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sabs_dp #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_predecessor(out_predecessor),
    .out_key_out    (out_key_out),
    .out_entry_count(out_entry_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

[sim/sorted_array_binary_search_unit_tb.sv]
// Self-checking testbench for sorted_array_binary_search_unit.
// Depends on sabs_pkg; an internal shadow of the sorted key table predicts each reply,
// and directed tests are followed by phased random traffic over several register settings.
module sorted_array_binary_search_unit_tb;
  import sabs_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int IDLE_PCT = 38;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 105;
  localparam int NUM_PHASES = 11;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SIGNED = 2'b01;
  localparam logic [MODE_W-1:0] MODE_DESCEND = 2'b10;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } traffic_mix_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_W-1:0]        slot;
    logic signed [PRED_W-1:0] pred;
    logic [IO_KEY_W-1:0]      key;
    logic [ECOUNT_W-1:0]      entries;
  } table_reply_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation;
  logic [IO_KEY_W-1:0]      in_key;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic                     out_ready;
  logic [STATUS_W-1:0]      out_status;
  logic [SLOT_W-1:0]        out_slot;
  logic signed [PRED_W-1:0] out_predecessor;
  logic [IO_KEY_W-1:0]      out_key_out;
  logic [ECOUNT_W-1:0]      out_entry_count;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  logic [IO_KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int                  shadow_count;
  logic [CAP_W-1:0]    shadow_cap;
  logic [MODE_W-1:0]   shadow_mode;

  table_reply_t op_replies_due [$];
  bit           no_gaps;
  int           reply_errors;
  int           replies_checked;
  int           ops_issued [8];
  int           status_seen [8];
  int           peak_entries;

  logic [IO_KEY_W-1:0] boundary_keys [6] = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                             32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

  sorted_array_binary_search_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_predecessor (out_predecessor),
    .out_key_out     (out_key_out),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d replies still outstanding", op_replies_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int order_of(logic [IO_KEY_W-1:0] a, logic [IO_KEY_W-1:0] b);
    int r;
    if ((shadow_mode & MODE_SIGNED) != 0) begin
      a[IO_KEY_W-1] = ~a[IO_KEY_W-1];
      b[IO_KEY_W-1] = ~b[IO_KEY_W-1];
    end
    r = (a < b) ? -1 : ((a > b) ? 1 : 0);
    if ((shadow_mode & MODE_DESCEND) != 0) r = -r;
    return r;
  endfunction

  function automatic int search_shadow(logic [IO_KEY_W-1:0] key, output int pred);
    int lo;
    int hi;
    int mid;
    int r;
    lo = 0;
    hi = shadow_count - 1;
    pred = -1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      r = order_of(shadow_keys[mid], key);
      if (r < 0) begin
        lo = mid + 1;
        pred = mid;
      end else if (r == 0) begin
        pred = mid - 1;
        return mid;
      end else begin
        hi = mid - 1;
      end
    end
    return -1;
  endfunction

  function automatic logic [IO_KEY_W-1:0] take_shadow(int idx);
    logic [IO_KEY_W-1:0] k;
    k = shadow_keys[idx];
    for (int i = idx; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
    shadow_count--;
    return k;
  endfunction

  function automatic table_reply_t apply_table_op(logic [OP_W-1:0] op, logic [IO_KEY_W-1:0] key,
                                                  logic [POS_W-1:0] pos);
    table_reply_t rep;
    int limit;
    int idx;
    int pred;
    rep = '0;
    limit = (shadow_cap < TABLE_DEPTH) ? int'(shadow_cap) : TABLE_DEPTH;
    case (op)
      OP_FIND: begin
        idx = search_shadow(key, pred);
        rep.pred = PRED_W'(pred);
        if (idx >= 0) rep.slot = SLOT_W'(idx);
        else rep.status = ST_NOT_FOUND;
      end
      OP_INSERT: begin
        if (shadow_count >= limit) begin
          rep.status = ST_FULL;
        end else begin
          idx = search_shadow(key, pred);
          if (idx >= 0) begin
            rep.status = ST_PRESENT;
            rep.slot = SLOT_W'(idx);
          end else begin
            for (int i = shadow_count; i > pred + 1; i--) shadow_keys[i] = shadow_keys[i - 1];
            shadow_keys[pred + 1] = key;
            shadow_count++;
            rep.slot = SLOT_W'(pred + 1);
          end
        end
      end
      OP_REMOVE_KEY: begin
        idx = search_shadow(key, pred);
        if (idx < 0) begin
          rep.status = ST_NOT_FOUND;
        end else begin
          rep.slot = SLOT_W'(idx);
          rep.key = take_shadow(idx);
        end
      end
      OP_REMOVE_IDX: begin
        if (pos >= shadow_count) begin
          rep.status = ST_RANGE;
        end else begin
          rep.slot = pos;
          rep.key = take_shadow(pos);
        end
      end
      OP_GET: begin
        if (pos >= shadow_count) begin
          rep.status = ST_RANGE;
        end else begin
          rep.slot = pos;
          rep.key = shadow_keys[pos];
        end
      end
      default: begin
      end
    endcase
    rep.entries = ECOUNT_W'(shadow_count);
    return rep;
  endfunction

  function automatic logic [IO_KEY_W-1:0] pick_key();
    int r;
    logic [IO_KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (shadow_count != 0 && r < 45) begin
      k = shadow_keys[$urandom_range(0, shadow_count - 1)];
      if (r >= 30) k = (r % 2 == 0) ? k + 1 : k - 1;
    end else if (r < 60) begin
      k = boundary_keys[$urandom_range(0, 5)];
    end else if (r < 80) begin
      k = $urandom_range(0, 255);
    end else begin
      k = $urandom();
    end
    return k;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 75)
      return POS_W'($urandom_range(0, (shadow_count < TABLE_DEPTH) ? shadow_count
                                                                    : TABLE_DEPTH - 1));
    return POS_W'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(traffic_mix_t mix);
    int r;
    int w_ins;
    int w_find;
    int w_rmk;
    int w_rmi;
    int w_get;
    case (mix)
      MIX_FILL: begin
        w_ins = 70; w_find = 10; w_rmk = 5; w_rmi = 5; w_get = 5;
      end
      MIX_DRAIN: begin
        w_ins = 10; w_find = 15; w_rmk = 35; w_rmi = 30; w_get = 5;
      end
      default: begin
        w_ins = 30; w_find = 25; w_rmk = 15; w_rmi = 10; w_get = 15;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_ins) return OP_INSERT;
    r -= w_ins;
    if (r < w_find) return OP_FIND;
    r -= w_find;
    if (r < w_rmk) return OP_REMOVE_KEY;
    r -= w_rmk;
    if (r < w_rmi) return OP_REMOVE_IDX;
    r -= w_rmi;
    if (r < w_get) return OP_GET;
    return OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IO_KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
    table_reply_t rep;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_position  <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rep = apply_table_op(op, key, pos);
    op_replies_due.push_back(rep);
    ops_issued[op]++;
    status_seen[rep.status]++;
    if (shadow_count > peak_entries) peak_entries = shadow_count;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (op_replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CAP_W-1:0] cap, input logic [MODE_W-1:0] mode);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_cap = cap;
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_mode = mode;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    table_reply_t got;
    table_reply_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_status, out_slot, out_predecessor, out_key_out, out_entry_count};
        replies_checked++;
        if (op_replies_due.size() == 0) begin
          reply_errors++;
          if (reply_errors <= MAX_REPORTS)
            $display("Unexpected reply: status %0d slot %0d pred %0d key %h count %0d",
                     got.status, got.slot, got.pred, got.key, got.entries);
        end else begin
          want = op_replies_due.pop_front();
          if (got.status !== want.status || got.slot !== want.slot || got.pred !== want.pred ||
              got.key !== want.key || got.entries !== want.entries) begin
            reply_errors++;
            if (reply_errors <= MAX_REPORTS)
              $display("Reply %0d mismatch: expected st %0d slot %0d pred %0d key %h cnt %0d, %s",
                       replies_checked, want.status, want.slot, want.pred, want.key,
                       want.entries, $sformatf("got st %0d slot %0d pred %0d key %h cnt %0d",
                       got.status, got.slot, got.pred, got.key, got.entries));
          end
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(OP_FIND, 32'h0, '0);
    send_item(OP_REMOVE_KEY, 32'h0000_1234, '0);
    send_item(OP_REMOVE_IDX, 32'h0, '0);
    send_item(OP_GET, 32'h0, 6'd63);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_item(OP_W'(op), 32'hFFFF_FFFF, 6'd63);
  endtask

  task automatic test_key_extremes();
    send_item(OP_INSERT, 32'h0000_0000, '0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, '0);
    send_item(OP_INSERT, 32'h8000_0000, '0);
    send_item(OP_INSERT, 32'h7FFF_FFFF, '0);
    send_item(OP_INSERT, 32'h0000_0000, '0);
    send_item(OP_FIND, 32'h7FFF_FFFF, '0);
    send_item(OP_FIND, 32'h0000_0001, '0);
    send_item(OP_GET, 32'h0, 6'd3);
    send_item(OP_GET, 32'h0, 6'd4);
    send_item(OP_REMOVE_IDX, 32'h0, 6'd0);
    send_item(OP_REMOVE_KEY, 32'hFFFF_FFFF, '0);
    send_item(OP_REMOVE_KEY, 32'h0000_0005, '0);
  endtask

  task automatic test_capacity_limits();
    wait_drained();
    set_config(7'd2, 2'd0);
    send_item(OP_INSERT, 32'd42, '0);
    send_item(OP_INSERT, 32'h7FFF_FFFF, '0);
    wait_drained();
    set_config(7'd1, 2'd0);
    send_item(OP_INSERT, 32'd42, '0);
    wait_drained();
    set_config(7'd0, MODE_SIGNED);
    send_item(OP_FIND, 32'h8000_0000, '0);
    send_item(OP_INSERT, 32'd42, '0);
    wait_drained();
    set_config(7'd127, MODE_SIGNED | MODE_DESCEND);
    send_item(OP_INSERT, 32'd42, '0);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0]  phase_cap [NUM_PHASES] = '{7'd64, 7'd64, 7'd127, 7'd12, 7'd0, 7'd64,
                                                   7'd3, 7'd100, 7'd64, 7'd1, 7'd64};
    logic [MODE_W-1:0] phase_mode [NUM_PHASES] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3,
                                                   2'd2, 2'd1, 2'd0, 2'd0, 2'd1};
    traffic_mix_t mix;
    logic [OP_W-1:0] op;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_config(phase_cap[p], phase_mode[p]);
      no_gaps = (p == 5);
      mix = traffic_mix_t'(p % 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_op(mix);
        send_item(op, pick_key(), pick_position());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_FIND;
    in_key       <= '0;
    in_position  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_CAPACITY;
    cfg_data     <= '0;
    no_gaps      = 1'b0;
    shadow_count = 0;
    shadow_cap   = CAP_RESET;
    shadow_mode  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_key_extremes();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Checked %0d replies: %0d inserts, %0d finds, %0d key removals, %0d index removals,",
             replies_checked, ops_issued[OP_INSERT], ops_issued[OP_FIND],
             ops_issued[OP_REMOVE_KEY], ops_issued[OP_REMOVE_IDX]);
    $display("%0d gets, %0d unused codes; peak %0d entries, %0d full, %0d out of range, %0d dup",
             ops_issued[OP_GET], ops_issued[5] + ops_issued[6] + ops_issued[7], peak_entries,
             status_seen[ST_FULL], status_seen[ST_RANGE], status_seen[ST_PRESENT]);
    if (reply_errors == 0 && op_replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatching replies", reply_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
